### design/linear_vector_resampler_assert.svh
// Assertion helpers for the checker file.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef LINEAR_VECTOR_RESAMPLER_ASSERT_SVH
`define LINEAR_VECTOR_RESAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LVR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

### design/lvr_pkg.sv
package lvr_pkg;

  localparam int unsigned MAX_LEN     = 1024;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = 16;

  localparam int unsigned IDX_W     = 10;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned LEN_RESET = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_LEN  = 1'b0,
    REG_OUT_LEN = 1'b1
  } reg_idx_e;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef struct packed {
    logic load_wr;
    logic capture;
    logic mul_en;
    logic div_init;
    logic div_step;
    logic rd_en;
    logic rd_next;
    logic a_load;
    logic mac_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_status_t;

endpackage

### design/lvr_if.sv
interface lvr_in_if #(
  parameter int unsigned SAMPLE_BITS = lvr_pkg::SAMPLE_BITS
) ();
  import lvr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [IDX_W-1:0]              index;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, func, index, sample, input ready);
  modport sink (input valid, func, index, sample, output ready);
endinterface

interface lvr_out_if #(
  parameter int unsigned SAMPLE_BITS = lvr_pkg::SAMPLE_BITS
) ();
  import lvr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [IDX_W-1:0]              out_index;
  logic signed [SAMPLE_BITS-1:0] out_value;

  modport source (output valid, out_index, out_value, input ready);
  modport sink (input valid, out_index, out_value, output ready);
endinterface

### design/lvr_ram.sv
module lvr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lvr_ctrl.sv
module lvr_ctrl #(
  parameter int unsigned FRAC_BITS = lvr_pkg::FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_func_i,
  output logic                  in_ready_o,
  input  lvr_pkg::ctrl_status_t status_i,
  output lvr_pkg::ctrl_cmd_t    cmd_o
);
  import lvr_pkg::*;

  localparam int unsigned QuoW = LEN_W + FRAC_BITS;
  localparam int unsigned CntW = $clog2(QuoW);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_INIT = 8'b0000_0100,
    S_DIV  = 8'b0000_1000,
    S_RDA  = 8'b0001_0000,
    S_RDB  = 8'b0010_0000,
    S_MAC  = 8'b0100_0000,
    S_SUM  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == FUNC_QUERY) begin
            cmd_o.capture = 1'b1;
            state_d       = S_MUL;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_INIT;
      end
      S_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = CntW'(QuoW - 1);
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_RDA;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_RDA: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RDB;
      end
      S_RDB: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
        cmd_o.a_load  = 1'b1;
        state_d       = S_MAC;
      end
      S_MAC: begin
        cmd_o.mac_en = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        // The result waits here until the output register can take it.
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### design/lvr_datapath.sv
module lvr_datapath #(
  parameter int unsigned MAX_LEN     = lvr_pkg::MAX_LEN,
  parameter int unsigned SAMPLE_BITS = lvr_pkg::SAMPLE_BITS,
  parameter int unsigned FRAC_BITS   = lvr_pkg::FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lvr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lvr_pkg::LEN_W-1:0]        cfg_wdata_i,
  input  lvr_pkg::ctrl_cmd_t               cmd_i,
  output lvr_pkg::ctrl_status_t            status_o,
  input  logic [lvr_pkg::IDX_W-1:0]        in_index_i,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [lvr_pkg::IDX_W-1:0]        out_index_o,
  output logic signed [SAMPLE_BITS-1:0]    out_value_o
);
  import lvr_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_LEN);
  localparam int unsigned ProdW = IDX_W + LEN_W;
  localparam int unsigned QuoW  = LEN_W + FRAC_BITS;
  localparam int unsigned AccW  = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic signed [AccW-1:0] Half = AccW'(64'd1 << (FRAC_BITS - 1));

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > MAX_LEN) begin
      r = LEN_W'(MAX_LEN);
    end
    return r;
  endfunction

  // Lengths are stored already clamped to 1..MAX_LEN.
  logic [LEN_W-1:0] in_len_q, out_len_q;
  logic [LEN_W-1:0] lin_m1, lout_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_len_q  <= clamp_len(LEN_W'(LEN_RESET));
      out_len_q <= clamp_len(LEN_W'(LEN_RESET));
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IN_LEN:  in_len_q  <= clamp_len(cfg_wdata_i);
        REG_OUT_LEN: out_len_q <= clamp_len(cfg_wdata_i);
      endcase
    end
  end

  assign lin_m1  = in_len_q - 1'b1;
  assign lout_m1 = out_len_q - 1'b1;

  // Query operands and the position numerator.
  logic [IDX_W-1:0] idx_q;
  logic [ProdW-1:0] prod_q;
  logic             direct_q;
  logic [LEN_W-1:0] dir_addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q <= in_index_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(idx_q) * ProdW'(lin_m1);
      // At or past the last point the position saturates, and a single
      // output point always maps to the first sample.
      direct_q   <= (out_len_q == LEN_W'(1)) || (in_len_q == LEN_W'(1)) ||
                    (LEN_W'(idx_q) >= lout_m1);
      dir_addr_q <= (out_len_q == LEN_W'(1)) ? '0 : lin_m1;
    end
  end

  // Restoring divider, one quotient bit per cycle. When the position is not
  // saturated the quotient is below in_len-1, so its top bits start the
  // remainder and only LEN_W integer plus FRAC_BITS fraction bits remain.
  logic [LEN_W-1:0] rem_q;
  logic [QuoW-1:0]  dvd_q;
  logic [LEN_W:0]   trial;
  logic             trial_ge;

  assign trial    = {rem_q, dvd_q[QuoW-1]};
  assign trial_ge = trial >= {1'b0, lout_m1};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= LEN_W'(prod_q[ProdW-1:LEN_W]);
      dvd_q <= {prod_q[LEN_W-1:0], FRAC_BITS'(0)};
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? LEN_W'(trial - {1'b0, lout_m1}) : LEN_W'(trial);
      dvd_q <= {dvd_q[QuoW-2:0], trial_ge};
    end
  end

  logic [LEN_W-1:0]     lo;
  logic [FRAC_BITS-1:0] frac;
  logic [LEN_W-1:0]     base;

  assign lo   = dvd_q[QuoW-1:FRAC_BITS];
  assign frac = direct_q ? '0 : dvd_q[FRAC_BITS-1:0];
  assign base = direct_q ? dir_addr_q : lo;

  // Sample store.
  logic                          ram_we;
  logic [AddrW-1:0]              ram_raddr;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] rdata_s;

  assign ram_we    = cmd_i.load_wr && (32'(in_index_i) < MAX_LEN);
  assign ram_raddr = cmd_i.rd_next ? AddrW'(base + 1'b1) : AddrW'(base);
  assign rdata_s   = signed'(ram_rdata);

  lvr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LEN)
  ) u_lvr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(in_index_i)),
    .wdata_i (in_sample_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Interpolation: a*2^F + f*(b-a) + half, then an arithmetic shift.
  logic signed [SAMPLE_BITS-1:0] a_q;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [AccW-1:0]        mprod_q;
  logic signed [AccW-1:0]        acc;

  // With no fraction the upper neighbor is not needed and may be unwritten.
  assign diff = (frac == '0) ? '0
                : (SAMPLE_BITS + 1)'(rdata_s) - (SAMPLE_BITS + 1)'(a_q);
  assign acc  = (AccW'(a_q) <<< FRAC_BITS) + mprod_q + Half;

  always_ff @(posedge clk_i) begin
    if (cmd_i.a_load) begin
      a_q <= rdata_s;
    end
    if (cmd_i.mac_en) begin
      mprod_q <= AccW'(signed'({1'b0, frac})) * AccW'(diff);
    end
  end

  // Output register.
  logic                          out_valid_q;
  logic [IDX_W-1:0]              out_index_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_q <= idx_q;
      out_value_q <= acc[FRAC_BITS +: SAMPLE_BITS];
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_index_o       = out_index_q;
  assign out_value_o       = out_value_q;

endmodule

### design/linear_vector_resampler.sv
// Channel   Dir  Handshake        Payload
// in_i      in   valid / ready    func, index, sample
// out_o     out  valid / ready    out_index, out_value
// cfg       in   cfg_we_i         cfg_index_i, cfg_wdata_i (in_len, out_len)
//
// Loads may follow each other every cycle while the block is idle. A query item
// runs through multiply, divider setup, the bit-serial divider that forms the
// position (one quotient bit per cycle), both store reads, MAC and output.
// Reset clears the length registers to their defaults; the store is not cleared.
// A stalled output holds its result; the next item is taken meanwhile, and a
// second query waits in its last step until the output register frees up.
module linear_vector_resampler #(
  parameter int unsigned MAX_LEN     = lvr_pkg::MAX_LEN,
  parameter int unsigned SAMPLE_BITS = lvr_pkg::SAMPLE_BITS,
  parameter int unsigned FRAC_BITS   = lvr_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lvr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lvr_pkg::LEN_W-1:0]     cfg_wdata_i,
  lvr_in_if.sink                        in_i,
  lvr_out_if.source                     out_o
);
  import lvr_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  lvr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_lvr_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lvr_datapath #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_lvr_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_index_i  (in_i.index),
    .in_sample_i (in_i.sample),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_index_o (out_o.out_index),
    .out_value_o (out_o.out_value)
  );

endmodule

### design/lvr_checker.sv
`include "linear_vector_resampler_assert.svh"

module lvr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_func_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  import lvr_pkg::*;

  logic       query_acc, out_acc;
  logic [1:0] pending_q, pending_d;

  assign query_acc = in_valid_i && in_ready_i && (in_func_i == FUNC_QUERY);
  assign out_acc   = out_valid_i && out_ready_i;

  // Queries accepted whose result has not been taken yet.
  always_comb begin
    pending_d = pending_q;
    if (query_acc && !out_acc) begin
      pending_d = pending_q + 1'b1;
    end else if (out_acc && !query_acc) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `LVR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `LVR_ASSERT_NEXT(a_busy_after_query, query_acc, !in_ready_i)
  `LVR_ASSERT_NOW(a_no_spurious_item, out_valid_i, pending_q != 2'd0)
  `LVR_ASSERT_NOW(a_pending_bound, 1'b1, pending_q != 2'd3)

endmodule

bind linear_vector_resampler lvr_checker u_lvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

### test/linear_vector_resampler_tb.sv
module linear_vector_resampler_tb;
  import lvr_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int QUERY_CYCLES = LEN_W + FRAC_BITS + 7;
  localparam int unsigned TOTAL_ITEMS = 650;
  localparam longint TIMEOUT_CYCLES = 1000000;
  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_W-1:0] index_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef struct {
    index_t  index;
    sample_t value;
  } point_t;

  // A length register of zero acts as one, anything above the store size saturates.
  function automatic int unsigned used_len(len_t v);
    if (v == 0) return 1;
    if (v > MAX_LEN) return MAX_LEN;
    return 32'(v);
  endfunction

  class resample_scoreboard;
    sample_t samples [MAX_LEN];
    bit written [MAX_LEN];
    len_t in_len_reg;
    len_t out_len_reg;
    point_t expected_points[$];
    int unsigned fails;

    function new();
      in_len_reg = len_t'(LEN_RESET);
      out_len_reg = len_t'(LEN_RESET);
      fails = 0;
    endfunction

    function void set_reg(reg_idx_e r, len_t v);
      if (r == REG_IN_LEN) begin
        in_len_reg = v;
      end else begin
        out_len_reg = v;
      end
    endfunction

    // Position of output point i in the stored vector, split into the lower
    // store entry and the fractional weight of the entry above it.
    function void locate(index_t i, output int unsigned lo, output longint frac,
                         output bit last);
      longint unsigned n_in, n_out, pos, ii;
      n_in = 64'(used_len(in_len_reg));
      n_out = 64'(used_len(out_len_reg));
      ii = 64'(i);
      pos = 0;
      if (n_out > 1) pos = ((ii * (n_in - 1)) << FRAC_BITS) / (n_out - 1);
      last = (pos >> FRAC_BITS) >= n_in - 1;
      lo = 32'(last ? n_in - 1 : pos >> FRAC_BITS);
      frac = pos & (FRAC_ONE - 1);
    endfunction

    function sample_t interpolate(index_t i);
      int unsigned lo;
      longint frac, a, b, acc;
      bit last;
      locate(i, lo, frac, last);
      if (last) return samples[lo];
      a = longint'(samples[lo]);
      b = longint'(samples[lo + 1]);
      // Adding one half before the floor sends ties toward plus infinity.
      acc = (FRAC_ONE - frac) * a + frac * b + FRAC_ONE / 2;
      return sample_t'(acc >>> FRAC_BITS);
    endfunction

    function void note_input(func_e f, index_t i, sample_t s);
      point_t p;
      if (f == FUNC_LOAD) begin
        samples[i] = s;
        written[i] = 1'b1;
      end else begin
        p.index = i;
        p.value = interpolate(i);
        expected_points.push_back(p);
      end
    endfunction

    function void check_result(index_t i, sample_t v);
      point_t p;
      if (expected_points.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result: index %0d value %0d", i, v);
        return;
      end
      p = expected_points.pop_front();
      if (p.index !== i || p.value !== v) begin
        fails++;
        if (fails <= 10)
          $display("result differs: expected index %0d value %0d, got index %0d value %0d",
                   p.index, p.value, i, v);
      end
    endfunction

    function int unsigned pending();
      return expected_points.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  reg_idx_e cfg_index;
  len_t cfg_wdata;

  lvr_in_if in_if ();
  lvr_out_if out_if ();

  linear_vector_resampler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  resample_scoreboard sb = new();
  int unsigned items_sent;
  bit sender_calm;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 11))
      0: return sample_t'(-32768);
      1: return sample_t'(32767);
      2: return sample_t'(0);
      3: return sample_t'(-1);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Small lengths dominate so that most queries stay cheap to set up.
  function automatic len_t pick_len();
    case ($urandom_range(0, 19))
      0: return len_t'(0);
      1: return len_t'(1);
      2: return len_t'(MAX_LEN);
      3: return len_t'($urandom_range(MAX_LEN + 1, 2047));
      4: return len_t'($urandom_range(2, MAX_LEN));
      default: return len_t'($urandom_range(2, 40));
    endcase
  endfunction

  task automatic send_item(func_e f, index_t i, sample_t s);
    int unsigned gap;
    gap = (sender_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func <= f;
    in_if.index <= i;
    in_if.sample <= s;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(f, i, s);
    items_sent++;
  endtask

  // Store entries that a query reads get loaded first if they never were.
  task automatic send_query(index_t i);
    int unsigned lo;
    longint frac;
    bit last;
    sb.locate(i, lo, frac, last);
    if (!sb.written[lo]) send_item(FUNC_LOAD, index_t'(lo), pick_sample());
    if (!last && !sb.written[lo + 1]) send_item(FUNC_LOAD, index_t'(lo + 1), pick_sample());
    send_item(FUNC_QUERY, i, sample_t'($urandom));
  endtask

  // Lengths change only with the block idle; a trailing load leaves no result
  // behind, so a query's worth of cycles is let pass as well.
  task automatic set_lengths(len_t n_in, len_t n_out);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (QUERY_CYCLES + 6) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= REG_IN_LEN;
    cfg_wdata <= n_in;
    @(posedge clk_i);
    sb.set_reg(REG_IN_LEN, n_in);
    cfg_index <= REG_OUT_LEN;
    cfg_wdata <= n_out;
    @(posedge clk_i);
    sb.set_reg(REG_OUT_LEN, n_out);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    index_t qi;
    len_t li, lo_len;
    int unsigned n_in, n_out, burst;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_IN_LEN;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.func <= FUNC_LOAD;
    in_if.index <= '0;
    in_if.sample <= '0;
    sender_calm = 1'b0;
    items_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Equal lengths at the reset setting copy the samples, extremes included.
    send_item(FUNC_LOAD, index_t'(0), sample_t'(-32768));
    send_item(FUNC_LOAD, index_t'(1), sample_t'(32767));
    send_item(FUNC_LOAD, index_t'(1022), sample_t'(21845));
    send_item(FUNC_LOAD, index_t'(1023), sample_t'(-1));
    send_query(index_t'(0));
    send_query(index_t'(1));
    send_query(index_t'(1022));
    send_query(index_t'(1023));

    // Midpoints between two samples hit the rounding ties; index 1023 lies
    // past the last output point.
    set_lengths(len_t'(2), len_t'(3));
    send_item(FUNC_LOAD, index_t'(0), sample_t'(0));
    send_item(FUNC_LOAD, index_t'(1), sample_t'(-1));
    send_query(index_t'(1));
    send_item(FUNC_LOAD, index_t'(1), sample_t'(1));
    send_query(index_t'(1));
    send_item(FUNC_LOAD, index_t'(0), sample_t'(-32768));
    send_item(FUNC_LOAD, index_t'(1), sample_t'(32767));
    send_query(index_t'(1));
    send_query(index_t'(2));
    send_query(index_t'(1023));

    // Zero lengths act as one: every query returns the first sample.
    set_lengths(len_t'(0), len_t'(0));
    send_query(index_t'(0));
    send_query(index_t'(1023));

    set_lengths(len_t'(2047), len_t'(MAX_LEN));
    send_query(index_t'(512));

    set_lengths(len_t'(MAX_LEN), len_t'(2));
    send_query(index_t'(0));
    send_query(index_t'(1));

    while (items_sent < TOTAL_ITEMS) begin
      li = pick_len();
      lo_len = ($urandom_range(0, 4) == 0) ? li : pick_len();
      set_lengths(li, lo_len);
      n_in = used_len(li);
      n_out = used_len(lo_len);
      burst = $urandom_range(10, 60);
      repeat (burst) begin
        if (items_sent >= TOTAL_ITEMS) break;
        if ($urandom_range(0, 9) < 3) begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(FUNC_LOAD, index_t'($urandom), pick_sample());
          end else begin
            send_item(FUNC_LOAD, index_t'($urandom_range(0, n_in - 1)), pick_sample());
          end
        end else begin
          case ($urandom_range(0, 9))
            0: qi = index_t'($urandom);
            1: qi = index_t'(n_out - 1);
            2: qi = '0;
            default: qi = index_t'($urandom_range(0, n_out - 1));
          endcase
          send_query(qi);
        end
      end
    end

    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (QUERY_CYCLES + 10) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("linear_vector_resampler: match");
    end else begin
      $display("linear_vector_resampler: mismatch");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold, seen;
    bit pressed, calm;
    hold = 0;
    seen = 0;
    pressed = 1'b0;
    calm = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.out_index, out_if.out_value);
        seen++;
      end
      if ($urandom_range(0, 149) == 0) calm = !calm;
      // One long hold-off lets the block back up into its input.
      if (!pressed && seen == 60) begin
        pressed = 1'b1;
        hold = 500;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("linear_vector_resampler: mismatch");
    $finish;
  end

endmodule
